FILE: rtl/core/xed_pkg.sv
// ----------------------------------------------------------------------------
// xed_pkg
// Shared types, character codes and entity tables for the XML entity decoder.
// ----------------------------------------------------------------------------
package xed_pkg;

  // default depth of the held-reference buffer
  localparam int MAX_PENDING_DEF = 16;

  // number bases
  localparam int BASE_DEC = 10;
  localparam int BASE_HEX = 16;

  // named entities
  localparam int NUM_ENT = 5;

  // character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_X_LO   = 8'h78;
  localparam logic [7:0] CH_X_UP   = 8'h58;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_A_LO   = 8'h61;
  localparam logic [7:0] CH_F_LO   = 8'h66;
  localparam logic [7:0] CH_A_UP   = 8'h41;
  localparam logic [7:0] CH_F_UP   = 8'h46;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TILDE  = 8'h7E;

  // parser phase of a pending reference
  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_AMP    = 4'd1,
    PH_NAMED  = 4'd2,
    PH_NUMST  = 4'd3,
    PH_WS     = 4'd4,
    PH_SIGN   = 4'd5,
    PH_ZERO   = 4'd6,
    PH_PREFIX = 4'd7,
    PH_DIGITS = 4'd8
  } phase_t;

  // output control sequencer
  typedef enum logic [1:0] {
    CTL_RUN   = 2'd0,
    CTL_FLUSH = 2'd1,
    CTL_TAIL  = 2'd2
  } ctl_state_t;

  // numeric reference flags
  typedef struct packed {
    logic hex;
    logic neg;
    logic digit;
  } num_flags_t;

  // per-beat action from the parser
  typedef struct packed {
    logic       wr;         // store byte in held buffer
    logic       fail;       // replay held bytes, then the byte itself unless it is '&'
    logic       emit;       // one result right away
    logic       emit_end;   // that result is the end marker
    logic [7:0] emit_byte;
  } pact_t;

  // entity lengths including '&' and ';'
  function automatic logic [2:0] ent_len(input logic [2:0] k);
    case (k)
      3'd0:    ent_len = 3'd4;
      3'd1:    ent_len = 3'd4;
      3'd2:    ent_len = 3'd5;
      3'd3:    ent_len = 3'd6;
      3'd4:    ent_len = 3'd6;
      default: ent_len = 3'd0;
    endcase
  endfunction

  // replacement character of each entity
  function automatic logic [7:0] ent_char(input logic [2:0] k);
    case (k)
      3'd0:    ent_char = "<";
      3'd1:    ent_char = ">";
      3'd2:    ent_char = "&";
      3'd3:    ent_char = "'";
      3'd4:    ent_char = "\"";
      default: ent_char = 8'h00;
    endcase
  endfunction

  // text of each entity, one byte per position
  function automatic logic [7:0] ent_byte(input logic [2:0] k, input logic [2:0] pos);
    logic [47:0] txt;
    case (k)
      3'd0:    txt = {16'h0000, ";tl&"};
      3'd1:    txt = {16'h0000, ";tg&"};
      3'd2:    txt = {8'h00, ";pma&"};
      3'd3:    txt = ";sopa&";
      3'd4:    txt = ";touq&";
      default: txt = '0;
    endcase
    case (pos)
      3'd0:    ent_byte = txt[7:0];
      3'd1:    ent_byte = txt[15:8];
      3'd2:    ent_byte = txt[23:16];
      3'd3:    ent_byte = txt[31:24];
      3'd4:    ent_byte = txt[39:32];
      3'd5:    ent_byte = txt[47:40];
      default: ent_byte = 8'h00;
    endcase
  endfunction

endpackage

FILE: rtl/core/xed_parse.sv
// ----------------------------------------------------------------------------
// xed_parse
// Per-beat decision logic: given the pending-reference state and one input
// byte, picks hold / emit / fail and computes the next parser state.
// ----------------------------------------------------------------------------
module xed_parse import xed_pkg::*; #(
  parameter int MAX_PENDING = MAX_PENDING_DEF,
  localparam int CNT_W = $clog2(MAX_PENDING + 1)
) (
  input  logic [7:0]       c,
  input  phase_t           phase,
  input  logic [CNT_W-1:0] count,
  input  logic [4:0]       cand,
  input  logic [7:0]       value,
  input  num_flags_t       flags,
  output pact_t            act,
  output phase_t           phase_next,
  output logic [CNT_W-1:0] count_next,
  output logic [4:0]       cand_next,
  output logic [7:0]       value_next,
  output num_flags_t       flags_next
);

  // digit value, valid flag in bit 4
  function automatic logic [4:0] digit_of(input logic [7:0] b, input logic hex);
    if (b >= CH_0 && b <= CH_9) digit_of = {1'b1, 4'(b - CH_0)};
    else if (hex && b >= CH_A_LO && b <= CH_F_LO) digit_of = {1'b1, 4'(b - CH_A_LO + 8'd10)};
    else if (hex && b >= CH_A_UP && b <= CH_F_UP) digit_of = {1'b1, 4'(b - CH_A_UP + 8'd10)};
    else digit_of = 5'b0;
  endfunction

  function automatic logic is_ws(input logic [7:0] b);
    is_ws = (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
  endfunction

  logic [4:0]  dig;
  logic [11:0] acc;
  logic [7:0]  acc_sat;
  logic [4:0]  hit;
  logic [4:0]  done;
  logic        num_ok;

  // digit and accumulated value for the numeric phases
  always_comb begin
    dig = digit_of(c, flags.hex);
    acc = (flags.hex ? {value, 4'b0} : ({1'b0, value, 3'b0} + {3'b0, value, 1'b0}))
          + {8'b0, dig[3:0]};
    acc_sat = (acc > 12'd255) ? 8'hFF : acc[7:0];
    num_ok = flags.digit && !flags.neg &&
             ((value >= 8'd9 && value <= 8'd13) || (value >= 8'd32 && value <= 8'd126));
  end

  // named entity matching over the five candidates
  always_comb begin
    for (int k = 0; k < NUM_ENT; k++) begin
      hit[k] = cand[k] && (count < CNT_W'(ent_len(3'(k)))) &&
               (ent_byte(3'(k), count[2:0]) == c);
      done[k] = hit[k] && (count + CNT_W'(1) == CNT_W'(ent_len(3'(k))));
    end
  end

  // phase decision
  always_comb begin
    logic       hold_req;
    logic       fail_req;
    logic       emit_req;
    logic       emit_end;
    logic [7:0] emit_b;
    phase_t     hold_ph;
    logic [7:0] val_upd;
    num_flags_t flg_upd;
    logic [4:0] cand_upd;
    logic       lead;
    logic       first;
    logic       more;
    logic       nmatch;

    hold_req = 1'b0;
    fail_req = 1'b0;
    emit_req = 1'b0;
    emit_end = 1'b0;
    emit_b   = c;
    hold_ph  = phase;
    val_upd  = value;
    flg_upd  = flags;
    cand_upd = cand;
    lead     = 1'b0;
    first    = 1'b0;
    more     = 1'b0;
    nmatch   = 1'b0;

    case (phase)
      PH_AMP: begin
        if (c == CH_HASH) begin
          hold_req = 1'b1;
          hold_ph  = PH_NUMST;
        end else begin
          nmatch = 1'b1;
        end
      end
      PH_NAMED: nmatch = 1'b1;
      PH_NUMST: begin
        if (c == CH_X_LO) begin
          flg_upd.hex = 1'b1;
          hold_req    = 1'b1;
          hold_ph     = PH_WS;
        end else begin
          lead = 1'b1;
        end
      end
      PH_WS:   lead  = 1'b1;
      PH_SIGN: first = 1'b1;
      PH_ZERO: begin
        if (c == CH_X_LO || c == CH_X_UP) begin
          hold_req = 1'b1;
          hold_ph  = PH_PREFIX;
        end else begin
          more = 1'b1;
        end
      end
      PH_PREFIX: begin
        if (dig[4]) more = 1'b1;
        else fail_req = 1'b1;
      end
      PH_DIGITS: more = 1'b1;
      default: begin
        // idle or an unused code: treat as nothing pending
        if (c == CH_NUL) begin
          emit_req = 1'b1;
          emit_end = 1'b1;
        end else if (c == CH_AMP) begin
          hold_req = 1'b1;
          hold_ph  = PH_AMP;
        end else begin
          emit_req = 1'b1;
        end
      end
    endcase

    // whitespace and sign ahead of the digits
    if (lead) begin
      if (is_ws(c)) begin
        hold_req = 1'b1;
        hold_ph  = PH_WS;
      end else if (c == CH_PLUS || c == CH_MINUS) begin
        if (c == CH_MINUS) flg_upd.neg = 1'b1;
        hold_req = 1'b1;
        hold_ph  = PH_SIGN;
      end else begin
        first = 1'b1;
      end
    end

    // first digit of the number
    if (first) begin
      if (!dig[4]) begin
        fail_req = 1'b1;
      end else begin
        val_upd       = acc_sat;
        flg_upd.digit = 1'b1;
        hold_req      = 1'b1;
        hold_ph       = (flags.hex && dig[3:0] == 4'd0) ? PH_ZERO : PH_DIGITS;
      end
    end

    // further digits or the closing ';'
    if (more) begin
      if (dig[4]) begin
        val_upd       = acc_sat;
        flg_upd.digit = 1'b1;
        hold_req      = 1'b1;
        hold_ph       = PH_DIGITS;
      end else if (c == CH_SEMI && num_ok) begin
        emit_req = 1'b1;
        emit_b   = value;
      end else begin
        fail_req = 1'b1;
      end
    end

    // named entity step: lowest completed entity wins
    if (nmatch) begin
      if (done != 5'b0) begin
        emit_req = 1'b1;
        emit_b   = 8'h00;
        for (int k = NUM_ENT - 1; k >= 0; k--) begin
          if (done[k]) emit_b = ent_char(3'(k));
        end
      end else if (hit != 5'b0) begin
        cand_upd = hit;
        hold_req = 1'b1;
        hold_ph  = PH_NAMED;
      end else begin
        fail_req = 1'b1;
      end
    end

    // buffer full: pass the reference through verbatim
    if (hold_req && count >= CNT_W'(MAX_PENDING)) begin
      hold_req = 1'b0;
      fail_req = 1'b1;
    end

    // resolve the action and the next state
    act        = '0;
    phase_next = PH_IDLE;
    count_next = '0;
    cand_next  = 5'h1F;
    value_next = 8'h00;
    flags_next = '0;
    if (fail_req) begin
      act.fail = 1'b1;
      if (c == CH_AMP) begin
        // held entry 0 already holds '&'
        phase_next = PH_AMP;
        count_next = CNT_W'(1);
      end
    end else if (hold_req) begin
      act.wr     = 1'b1;
      phase_next = hold_ph;
      count_next = count + CNT_W'(1);
      cand_next  = cand_upd;
      value_next = val_upd;
      flags_next = flg_upd;
    end else if (emit_req) begin
      act.emit      = 1'b1;
      act.emit_end  = emit_end;
      act.emit_byte = emit_end ? CH_NUL : emit_b;
    end
  end

endmodule

FILE: rtl/core/xml_entity_decoder.sv
// ----------------------------------------------------------------------------
// xml_entity_decoder
// Streaming XML character-entity unescaper with a held-byte replay buffer.
// ----------------------------------------------------------------------------
// A result is in the output register in the cycle after its input beat is accepted.
// Throughput: one byte per cycle while references match or bytes pass through and the output is not back-pressured.
// A mismatch with N held bytes replays them from the held-byte RAM at one per
// cycle while the output accepts them, then the failing byte's own result unless it
// opens a new reference; input stalls meanwhile, paced by the RAM read port.
// Reset: synchronous, returns the parser to idle; the held-byte RAM keeps its
// contents and needs no clearing pass.
module xml_entity_decoder import xed_pkg::*; #(
  parameter int MAX_PENDING = MAX_PENDING_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] text_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tuser,   // [0] is_end
  output logic       m_axis_tlast    // last_of_run
);

  localparam int CNT_W = $clog2(MAX_PENDING + 1);
  localparam int IDX_W = $clog2(MAX_PENDING);

  // parser state
  phase_t           phase;
  logic [CNT_W-1:0] count;
  logic [4:0]       cand;
  logic [7:0]       value;
  num_flags_t       flags;

  phase_t           phase_next;
  logic [CNT_W-1:0] count_next;
  logic [4:0]       cand_next;
  logic [7:0]       value_next;
  num_flags_t       flags_next;
  pact_t            act;

  // sequencer and replay
  ctl_state_t       ctl;
  ctl_state_t       ctl_next;
  logic [IDX_W-1:0] rd_ptr;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] last_idx;
  logic [7:0]       tail_byte;
  logic             tail_has;
  logic [7:0]       rd_data;
  logic [7:0]       held_mem [MAX_PENDING];

  // output register
  logic       out_valid;
  logic [7:0] out_data;
  logic       out_end;
  logic       out_last;
  logic       out_free;
  logic       in_acc;
  logic       flush_take;
  logic       tail_take;

  xed_parse #(
    .MAX_PENDING(MAX_PENDING)
  ) u_parse (
    .c          (s_axis_tdata),
    .phase      (phase),
    .count      (count),
    .cand       (cand),
    .value      (value),
    .flags      (flags),
    .act        (act),
    .phase_next (phase_next),
    .count_next (count_next),
    .cand_next  (cand_next),
    .value_next (value_next),
    .flags_next (flags_next)
  );

  assign out_free = !out_valid || m_axis_tready;
  assign in_acc   = s_axis_tvalid && s_axis_tready;

  // sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    flush_take    = 1'b0;
    tail_take     = 1'b0;
    rd_addr       = '0;
    case (ctl)
      CTL_RUN: s_axis_tready = out_free;
      CTL_FLUSH: begin
        flush_take = out_free;
        rd_addr    = flush_take ? rd_ptr + IDX_W'(1) : rd_ptr;
      end
      CTL_TAIL: tail_take = out_free;
      default: ;
    endcase
  end

  // sequencer next state
  always_comb begin
    ctl_next = ctl;
    case (ctl)
      CTL_RUN: if (in_acc && act.fail) ctl_next = CTL_FLUSH;
      CTL_FLUSH: begin
        if (flush_take && rd_ptr == last_idx) ctl_next = tail_has ? CTL_TAIL : CTL_RUN;
      end
      CTL_TAIL: if (tail_take) ctl_next = CTL_RUN;
      default: ctl_next = CTL_RUN;
    endcase
  end

  // held-byte RAM, one write and one registered read port
  always_ff @(posedge clk) begin
    if (in_acc && act.wr) held_mem[count[IDX_W-1:0]] <= s_axis_tdata;
    rd_data <= held_mem[rd_addr];
  end

  // control and parser registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl    <= CTL_RUN;
      phase  <= PH_IDLE;
      count  <= '0;
      cand   <= 5'h1F;
      value  <= 8'h00;
      flags  <= '0;
      rd_ptr <= '0;
    end else begin
      ctl <= ctl_next;
      if (in_acc) begin
        phase <= phase_next;
        count <= count_next;
        cand  <= cand_next;
        value <= value_next;
        flags <= flags_next;
      end
      if (ctl == CTL_FLUSH) begin
        if (flush_take) rd_ptr <= (rd_ptr == last_idx) ? '0 : rd_ptr + IDX_W'(1);
      end else begin
        rd_ptr <= '0;
      end
    end
  end

  // replay bookkeeping, captured on a failing beat
  always_ff @(posedge clk) begin
    if (in_acc && act.fail) begin
      last_idx  <= IDX_W'(count - CNT_W'(1));
      tail_byte <= s_axis_tdata;
      tail_has  <= (s_axis_tdata != CH_AMP);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((in_acc && act.emit) || flush_take || tail_take) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && act.emit) begin
      out_data <= act.emit_byte;
      out_end  <= act.emit_end;
      out_last <= 1'b1;
    end else if (flush_take) begin
      out_data <= rd_data;
      out_end  <= 1'b0;
      out_last <= (rd_ptr == last_idx) && !tail_has;
    end else if (tail_take) begin
      out_data <= tail_byte;
      out_end  <= (tail_byte == CH_NUL);
      out_last <= 1'b1;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_end;
  assign m_axis_tlast  = out_last;

  // held count never runs past the buffer depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_PENDING))
    else $error("held count beyond buffer depth");

  // a failing beat always starts a replay
  a_fail_flush: assert property (@(posedge clk) disable iff (rst)
    (in_acc && act.fail) |=> (ctl == CTL_FLUSH))
    else $error("mismatch did not start replay");

  // replay pointer stays within the held run
  a_replay_ptr: assert property (@(posedge clk) disable iff (rst)
    (ctl == CTL_FLUSH) |-> (rd_ptr <= last_idx))
    else $error("replay pointer past held run");

  // the end marker is zero and closes its run
  a_end_beat: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_end) |-> (out_last && out_data == CH_NUL))
    else $error("malformed end beat");

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for xml_entity_decoder. Drives text bytes on the input
// stream and checks every output beat against a behavioral decoder that runs
// alongside the block. The bench covers directed references, then random
// well-formed and broken references under several idle, stall and
// back-pressure patterns.
// ----------------------------------------------------------------------------
module tb;
  import xed_pkg::*;

  localparam int MAX_PEND    = MAX_PENDING_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = MAX_PEND + 8;
  localparam int MAX_PRINTS  = 30;

  // one decoded output beat
  typedef struct packed {
    logic [7:0] ch;
    logic       eos;
    logic       last;
  } dec_beat_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;   // [7:0] text_byte
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // [7:0] out_byte
  logic       m_axis_tuser;           // [0] is_end
  logic       m_axis_tlast;           // last_of_run

  // bench control
  int idle_pct   = 0;
  int stall_pct  = 0;
  bit hold_req   = 1'b0;
  int hold_left  = 0;
  int beats_sent = 0;
  int errors     = 0;
  int cycles     = 0;

  // decoder shadow state
  phase_t     ph;
  logic [7:0] held [MAX_PEND];
  int         held_n;
  logic [4:0] cand;
  int         num_val;
  bit         f_hex, f_neg, f_dig;

  dec_beat_t  step_q[$];
  dec_beat_t  decoded_q[$];
  dec_beat_t  front;
  logic [7:0] chunk[$];

  string      ent_txt [5] = '{"&lt;", "&gt;", "&amp;", "&apos;", "&quot;"};
  logic [7:0] ent_ch  [5] = '{"<", ">", "&", "'", "\""};

  xml_entity_decoder #(.MAX_PENDING(MAX_PEND)) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  // ------------------------------------------------------------------
  // behavioral decoder
  // ------------------------------------------------------------------
  task automatic put_out(input logic [7:0] c, input logic e);
    dec_beat_t r;
    r.ch   = c;
    r.eos  = e;
    r.last = 1'b0;
    step_q.push_back(r);
  endtask

  task automatic clear_ref();
    ph      = PH_IDLE;
    held_n  = 0;
    cand    = 5'h1f;
    num_val = 0;
    f_hex   = 1'b0;
    f_neg   = 1'b0;
    f_dig   = 1'b0;
  endtask

  // byte seen with nothing pending
  task automatic start_byte(input logic [7:0] c);
    if (c == CH_NUL) begin
      put_out(8'h00, 1'b1);
    end else if (c == CH_AMP) begin
      held[0] = CH_AMP;
      held_n  = 1;
      ph      = PH_AMP;
    end else begin
      put_out(c, 1'b0);
    end
  endtask

  // replay held bytes verbatim, then treat c as fresh
  task automatic abandon_ref(input logic [7:0] c);
    for (int i = 0; i < held_n && i < MAX_PEND; i++) put_out(held[i], 1'b0);
    clear_ref();
    start_byte(c);
  endtask

  task automatic stash(input logic [7:0] c, input phase_t nxt);
    if (held_n >= MAX_PEND) begin
      abandon_ref(c);
    end else begin
      held[held_n] = c;
      held_n++;
      ph = nxt;
    end
  endtask

  function automatic int digit_value(input logic [7:0] c);
    if (c >= CH_0 && c <= CH_9) return c - CH_0;
    if (f_hex && c >= CH_A_LO && c <= CH_F_LO) return c - CH_A_LO + 10;
    if (f_hex && c >= CH_A_UP && c <= CH_F_UP) return c - CH_A_UP + 10;
    return -1;
  endfunction

  // accumulate with sticky saturation at 255
  task automatic fold_digit(input int d);
    int v;
    v       = num_val * (f_hex ? BASE_HEX : BASE_DEC) + d;
    num_val = (v > 255) ? 255 : v;
    f_dig   = 1'b1;
  endtask

  function automatic bit is_space(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  task automatic open_number(input logic [7:0] c);
    int d;
    d = digit_value(c);
    if (d < 0) begin
      abandon_ref(c);
    end else begin
      fold_digit(d);
      stash(c, (f_hex && d == 0) ? PH_ZERO : PH_DIGITS);
    end
  endtask

  task automatic continue_number(input logic [7:0] c);
    int d;
    int v;
    d = digit_value(c);
    v = num_val;
    if (d >= 0) begin
      fold_digit(d);
      stash(c, PH_DIGITS);
    end else if (c == CH_SEMI && f_dig && !f_neg &&
                 ((v >= 9 && v <= 13) || (v >= 32 && v <= 126))) begin
      put_out(v[7:0], 1'b0);
      clear_ref();
    end else begin
      abandon_ref(c);
    end
  endtask

  // whitespace and sign ahead of the digits
  task automatic lead_in(input logic [7:0] c);
    if (is_space(c)) begin
      stash(c, PH_WS);
    end else if (c == CH_PLUS || c == CH_MINUS) begin
      if (c == CH_MINUS) f_neg = 1'b1;
      stash(c, PH_SIGN);
    end else begin
      open_number(c);
    end
  endtask

  task automatic match_name(input logic [7:0] c);
    logic [4:0] m;
    bit         done;
    m    = '0;
    done = 1'b0;
    for (int k = 0; k < NUM_ENT; k++) begin
      if (!done && cand[k] && held_n < ent_txt[k].len() && ent_txt[k][held_n] == c) begin
        if (held_n + 1 == ent_txt[k].len()) begin
          put_out(ent_ch[k], 1'b0);
          clear_ref();
          done = 1'b1;
        end else begin
          m[k] = 1'b1;
        end
      end
    end
    if (!done) begin
      if (m != '0) begin
        cand = m;
        stash(c, PH_NAMED);
      end else begin
        abandon_ref(c);
      end
    end
  endtask

  // decode one accepted byte and queue its results
  task automatic decode_byte(input logic [7:0] c);
    dec_beat_t r;
    step_q.delete();
    case (ph)
      PH_IDLE:   start_byte(c);
      PH_AMP: begin
        if (c == CH_HASH) stash(c, PH_NUMST);
        else match_name(c);
      end
      PH_NAMED:  match_name(c);
      PH_NUMST: begin
        if (c == CH_X_LO) begin
          f_hex = 1'b1;
          stash(c, PH_WS);
        end else begin
          lead_in(c);
        end
      end
      PH_WS:     lead_in(c);
      PH_SIGN:   open_number(c);
      PH_ZERO: begin
        if (c == CH_X_LO || c == CH_X_UP) stash(c, PH_PREFIX);
        else continue_number(c);
      end
      PH_PREFIX: begin
        if (digit_value(c) >= 0) continue_number(c);
        else abandon_ref(c);
      end
      PH_DIGITS: continue_number(c);
      default: begin
        clear_ref();
        start_byte(c);
      end
    endcase
    for (int i = 0; i < step_q.size(); i++) begin
      r      = step_q[i];
      r.last = (i == step_q.size() - 1);
      decoded_q.push_back(r);
    end
  endtask

  // ------------------------------------------------------------------
  // output side: ready pattern, long hold-off and checker
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left     = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic report_err(input string what, input logic [7:0] got, input logic [7:0] want);
    if (errors < MAX_PRINTS)
      $display("tb: mismatch on %s: got %02h, want %02h", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (decoded_q.size() == 0) begin
        report_err("unexpected beat", m_axis_tdata, 8'h00);
      end else begin
        front = decoded_q.pop_front();
        if (m_axis_tdata !== front.ch)  report_err("out_byte", m_axis_tdata, front.ch);
        if (m_axis_tuser !== front.eos) report_err("is_end", m_axis_tuser, front.eos);
        if (m_axis_tlast !== front.last) report_err("last_of_run", m_axis_tlast, front.last);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // input side
  // ------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    decode_byte(b);
    beats_sent++;
  endtask

  task automatic send_chunk();
    while (chunk.size() != 0) send_byte(chunk.pop_front());
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) chunk.push_back(s[i]);
    send_chunk();
  endtask

  // sender goes quiet until every queued result has come out
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (decoded_q.size() != 0);
  endtask

  // ------------------------------------------------------------------
  // random stimulus builders
  // ------------------------------------------------------------------
  function automatic logic [7:0] rand_space();
    int k;
    k = $urandom_range(5);
    return (k == 5) ? CH_SPACE : CH_TAB + k[7:0];
  endfunction

  task automatic build_text();
    int n;
    n = $urandom_range(1, 5);
    repeat (n) chunk.push_back(8'($urandom_range(1, 255)));
  endtask

  task automatic build_named();
    int         k;
    int         mode;
    int         cut;
    k    = $urandom_range(NUM_ENT - 1);
    mode = $urandom_range(7);
    cut  = (mode == 0) ? $urandom_range(1, ent_txt[k].len() - 1) : ent_txt[k].len();
    for (int i = 0; i < cut; i++) chunk.push_back(ent_txt[k][i]);
    if (mode == 0) begin
      chunk.push_back(8'($urandom_range(1, 255)));
    end else if (mode == 1) begin
      // wrong final byte instead of ';'
      void'(chunk.pop_back());
      chunk.push_back(8'($urandom_range(8'h61, 8'h7a)));
    end
  endtask

  task automatic build_number();
    bit         hex;
    int         v;
    int         sel;
    int         nd;
    logic [7:0] dg [12];
    logic [7:0] c;
    hex = 1'($urandom_range(1));
    chunk.push_back(CH_AMP);
    chunk.push_back(CH_HASH);
    if (hex) chunk.push_back(($urandom_range(19) == 0) ? CH_X_UP : CH_X_LO);
    if ($urandom_range(3) == 0) repeat ($urandom_range(1, 2)) chunk.push_back(rand_space());
    case ($urandom_range(9))
      0: chunk.push_back(CH_PLUS);
      1: chunk.push_back(CH_MINUS);
      default: ;
    endcase
    if (hex && $urandom_range(3) == 0) begin
      chunk.push_back(CH_0);
      chunk.push_back($urandom_range(1) ? CH_X_LO : CH_X_UP);
    end
    if ($urandom_range(4) == 0) repeat ($urandom_range(1, 2)) chunk.push_back(CH_0);
    sel = $urandom_range(9);
    case (sel)
      6:       v = $urandom_range(9, 13);
      7:       v = $urandom_range(0, 255);
      8:       v = $urandom_range(256, 5000);
      default: v = $urandom_range(32, 126);
    endcase
    // digits, least significant first
    nd = 0;
    if (sel != 9) begin
      do begin
        c = 8'(v % (hex ? 16 : 10));
        if (c < 8'd10) c = CH_0 + c;
        else c = ($urandom_range(1) ? CH_A_LO : CH_A_UP) + c - 8'd10;
        dg[nd] = c;
        nd++;
        v = v / (hex ? 16 : 10);
      end while (v != 0);
    end
    for (int i = nd - 1; i >= 0; i--) chunk.push_back(dg[i]);
    chunk.push_back(($urandom_range(9) == 0) ? 8'($urandom_range(1, 255)) : CH_SEMI);
  endtask

  // a reference that can outgrow the held buffer
  task automatic build_overflow();
    int n;
    chunk.push_back(CH_AMP);
    chunk.push_back(CH_HASH);
    n = $urandom_range(MAX_PEND - 3, MAX_PEND + 4);
    repeat (n) chunk.push_back($urandom_range(1) ? rand_space() : CH_0);
    chunk.push_back(CH_SEMI);
  endtask

  task automatic build_chunk();
    int r;
    r = $urandom_range(99);
    if (r < 30)      build_text();
    else if (r < 55) build_named();
    else if (r < 85) build_number();
    else if (r < 90) build_overflow();
    else if (r < 95) chunk.push_back(CH_NUL);
    else repeat ($urandom_range(1, 3)) chunk.push_back(8'($urandom_range(0, 255)));
  endtask

  // ------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------
  // named references, a restart on a second '&'
  task automatic test_named();
    send_text("&gt;");
    send_text("&&amp;");
  endtask

  // negative value, hex with whitespace and 0X prefix
  task automatic test_numeric();
    send_text("&#-5;");
    send_text("&#x 0X7E;");
  endtask

  // byte extremes, end of string
  task automatic test_extremes();
    send_byte(8'hFF);
    send_byte(CH_NUL);
  endtask

  task automatic test_random(input int n, input int idle, input int stall);
    int start;
    idle_pct  = idle;
    stall_pct = stall;
    start     = beats_sent;
    while (beats_sent - start < n) begin
      build_chunk();
      send_chunk();
    end
    wait_drained();
  endtask

  // receiver holds off while the sender keeps pushing
  task automatic test_backpressure(input int n);
    int start;
    idle_pct  = 0;
    stall_pct = 0;
    hold_req  = 1'b1;
    start     = beats_sent;
    while (beats_sent - start < n) begin
      build_chunk();
      send_chunk();
    end
    wait_drained();
  endtask

  initial begin
    clear_ref();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_named();
    test_numeric();
    test_extremes();
    wait_drained();

    test_random(60, 0, 0);
    test_random(90, 86, 0);
    test_random(90, 0, 86);
    test_random(90, 23, 23);
    test_backpressure(90);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && decoded_q.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
